>>> sv/vfpq_pkg.sv
package vfpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int SUM_W       = IDX_W + 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAXC_W      = 5;
    localparam int PREROLL_W   = 4;
    localparam int CMP_W       = (OCC_W > MAXC_W) ? OCC_W : MAXC_W;
    localparam int TIME_W      = 64;
    localparam int HANDLE_W    = 32;
    localparam int ENTRY_W     = TIME_W + HANDLE_W + 1;
    localparam int CFG_DATA_W  = MAXC_W;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_EOS    = 3'd1;
    localparam logic [2:0] CMD_SEEK   = 3'd2;
    localparam logic [2:0] CMD_UPDATE = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    localparam logic REG_MAX_CACHED = 1'b0;
    localparam logic REG_PREROLL    = 1'b1;

    localparam logic [MAXC_W-1:0]    MAX_CACHED_RST = MAXC_W'(12);
    localparam logic [PREROLL_W-1:0] PREROLL_RST    = PREROLL_W'(8);

    typedef struct packed {
        logic [2:0]                 cmd;
        logic signed [TIME_W-1:0]   time_value;
        logic [HANDLE_W-1:0]        frame_handle;
        logic                       frame_present;
        logic                       frame_is_eos;
        logic                       decoder_needs_input;
    } t_in;

    typedef struct packed {
        logic                       frame_valid;
        logic signed [TIME_W-1:0]   frame_pts;
        logic [HANDLE_W-1:0]        out_handle;
        logic                       out_is_eos;
        logic                       can_accept;
        logic                       seeking_now;
        logic                       eos_played;
        logic                       sample_rejected;
        logic                       frame_dropped;
    } t_out;

endpackage

>>> sv/vfpq_ram.sv
module vfpq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/video_frame_presentation_queue_top.sv
// Channel  | Ports                               | Transfer
// ---------+-------------------------------------+------------------------------
// command  | start, busy, i_in                   | start high while busy low
// result   | o_done, o_result                    | one cycle on o_done, no stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data     | any edge with i_cfg_we high
//
// Non-query commands and a query on an empty queue: busy in S_EXEC only, result
// on the following cycle.
// Display query on a non-empty queue: busy through S_EXEC and S_CHECK, k = front
// frames dropped (at most occupancy - 1); the ring has one read port, one head per cycle.
// Reset is synchronous, active low; the frame ring is not cleared.
// Results cannot be stalled: o_done is a one-cycle strobe.
module video_frame_presentation_queue_top
    import vfpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_in,
    output logic                  o_done,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK
    } t_state;

    t_state                 r_state, n_state;
    t_in                    r_in, n_in;
    t_out                   r_out, n_out;
    logic                   r_done, n_done;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic                   r_seek, n_seek;
    logic signed [TIME_W-1:0] r_target, n_target;
    logic                   r_eos, n_eos;
    logic                   r_hungry, n_hungry;
    logic [MAXC_W-1:0]      r_max_cached;
    logic [PREROLL_W-1:0]   r_preroll;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic signed [TIME_W-1:0] rd_pts;
    logic [HANDLE_W-1:0]    rd_handle;
    logic                   rd_eos;
    logic [SUM_W-1:0]       slot_sum;
    logic [IDX_W-1:0]       tail_slot;
    logic [IDX_W-1:0]       head_inc;
    logic                   too_early;

    // Writes happen only in S_EXEC for an update and reads only for a query, so ring
    // accesses never overlap on the same entry.
    vfpq_ram #(
        .W (ENTRY_W),
        .D (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign {rd_pts, rd_handle, rd_eos} = ram_rdata;

    assign slot_sum  = SUM_W'(r_head) + SUM_W'(r_occ);
    assign tail_slot = (slot_sum >= SUM_W'(QUEUE_DEPTH))
                     ? IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH))
                     : IDX_W'(slot_sum);
    assign head_inc  = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign ram_waddr = tail_slot;
    assign ram_wdata = {r_in.time_value, r_in.frame_handle, r_in.frame_is_eos};

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_done    = 1'b0;
        n_head    = r_head;
        n_occ     = r_occ;
        n_seek    = r_seek;
        n_target  = r_target;
        n_eos     = r_eos;
        n_hungry  = r_hungry;
        n_out     = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        too_early = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in    = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_in.cmd)
                    CMD_WRITE: begin
                        if (r_eos) begin
                            n_out.sample_rejected = 1'b1;
                        end else begin
                            n_hungry = 1'b0;
                        end
                    end
                    CMD_EOS: begin
                        n_eos = 1'b1;
                    end
                    CMD_SEEK: begin
                        n_target = r_in.time_value[TIME_W-1] ? '0 : r_in.time_value;
                        n_seek   = 1'b1;
                        n_eos    = 1'b0;
                        n_occ    = '0;
                        n_head   = '0;
                    end
                    CMD_UPDATE: begin
                        if (r_in.frame_present) begin
                            if (r_seek) begin
                                if (r_in.frame_is_eos) begin
                                    n_seek = 1'b0;
                                end else if ($signed(r_in.time_value) < $signed(r_target)) begin
                                    too_early = 1'b1;
                                end
                            end
                            if (!too_early) begin
                                if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                                    n_out.frame_dropped = 1'b1;
                                end else begin
                                    ram_we = 1'b1;
                                    n_occ  = r_occ + 1'b1;
                                end
                            end
                            if (n_seek && (CMP_W'(n_occ) > CMP_W'(r_preroll))) begin
                                n_seek = 1'b0;
                            end
                        end
                        n_hungry = r_in.decoder_needs_input;
                    end
                    CMD_QUERY: begin
                        if (r_occ != '0) begin
                            ram_re  = 1'b1;
                            n_state = S_CHECK;
                            n_done  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CHECK: begin
                // rd_* holds the entry at r_head; pop stale fronts, keep the last
                if (r_occ > OCC_W'(1) && $signed(rd_pts) < $signed(r_in.time_value)) begin
                    n_head    = head_inc;
                    n_occ     = r_occ - 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = head_inc;
                end else begin
                    n_state           = S_IDLE;
                    n_done            = 1'b1;
                    n_out.frame_valid = 1'b1;
                    n_out.frame_pts   = rd_pts;
                    n_out.out_handle  = rd_handle;
                    n_out.out_is_eos  = rd_eos;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status reflects the state after the transaction
        n_out.can_accept  = (CMP_W'(n_occ) < CMP_W'(r_max_cached)) && !n_eos && n_hungry;
        n_out.seeking_now = n_seek;
        n_out.eos_played  = n_eos && (n_occ <= OCC_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_head       <= '0;
            r_occ        <= '0;
            r_seek       <= 1'b0;
            r_target     <= '0;
            r_eos        <= 1'b0;
            r_hungry     <= 1'b1;
            r_max_cached <= MAX_CACHED_RST;
            r_preroll    <= PREROLL_RST;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_seek   <= n_seek;
            r_target <= n_target;
            r_eos    <= n_eos;
            r_hungry <= n_hungry;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_CACHED: r_max_cached <= i_cfg_data;
                    REG_PREROLL:    r_preroll    <= PREROLL_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        if (n_done) begin
            r_out <= n_out;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

>>> sv/vfpq_checker.sv
module vfpq_checker
    import vfpq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_out o_result
);

    // a result appears exactly when the block goes idle
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted transaction did not make the block busy");

    a_eos_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.eos_played) |-> !o_result.can_accept)
        else $error("can_accept set after end of stream");

    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.frame_valid) |->
            (o_result.frame_pts == '0 && o_result.out_handle == '0 && !o_result.out_is_eos))
        else $error("frame fields nonzero without a frame");

endmodule

bind video_frame_presentation_queue_top vfpq_checker u_vfpq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

>>> tb/sv/video_frame_presentation_queue_top_tb.sv
module video_frame_presentation_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfpq_pkg::*;

    // commands five to seven are not decoded by the block
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam logic [TIME_W-1:0] PTS_MIN = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] PTS_MAX = {1'b0, {(TIME_W-1){1'b1}}};

    localparam int PHASE_ITEMS = 105;
    localparam int NUM_PHASES  = 6;
    localparam int BURST_LEN   = 20;
    localparam int PLAN_MAX    = 32;
    localparam int DUE_DEPTH   = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_in;
    logic                  o_done;
    t_out                  o_result;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    video_frame_presentation_queue_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame queue predictor
    // ------------------------------------------------------------------
    logic signed [TIME_W-1:0] ring_pts    [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]      ring_handle [QUEUE_DEPTH];
    logic                     ring_eos    [QUEUE_DEPTH];
    int                       head;
    int                       fill;
    bit                       seeking;
    bit                       eos_seen;
    bit                       hungry;
    logic signed [TIME_W-1:0] target;
    logic [MAXC_W-1:0]        max_cached;
    logic [PREROLL_W-1:0]     preroll;

    // expected results in flight, kept as a small ring
    t_out due_results [DUE_DEPTH];
    int   due_wr = 0;
    int   due_rd = 0;
    int   err_count = 0;
    bit   steady = 1'b0;
    logic signed [TIME_W-1:0] stream_pts;

    typedef struct {
        t_in  item;
        bit   fixed;
        t_out want;
    } t_row;

    t_row plan [PLAN_MAX];
    int   plan_len = 0;

    function automatic void due_put(t_out r);
        due_results[due_wr % DUE_DEPTH] = r;
        due_wr++;
    endfunction

    function automatic t_out due_take();
        t_out r;
        r = due_results[due_rd % DUE_DEPTH];
        due_rd++;
        return r;
    endfunction

    function automatic void reset_queue_model();
        head       = 0;
        fill       = 0;
        seeking    = 1'b0;
        eos_seen   = 1'b0;
        hungry     = 1'b1;
        target     = '0;
        max_cached = MAX_CACHED_RST;
        preroll    = PREROLL_RST;
    endfunction

    function automatic t_out predict_presentation(t_in x);
        t_out                     r;
        logic signed [TIME_W-1:0] tv;
        bit                       early;
        int                       slot;
        r     = '0;
        tv    = x.time_value;
        early = 1'b0;
        case (x.cmd)
            CMD_WRITE: begin
                if (eos_seen)
                    r.sample_rejected = 1'b1;
                else
                    hungry = 1'b0;
            end
            CMD_EOS: eos_seen = 1'b1;
            CMD_SEEK: begin
                target   = tv[TIME_W-1] ? '0 : tv;
                seeking  = 1'b1;
                eos_seen = 1'b0;
                fill     = 0;
                head     = 0;
            end
            CMD_UPDATE: begin
                if (x.frame_present) begin
                    if (seeking) begin
                        if (x.frame_is_eos)
                            seeking = 1'b0;
                        else if (tv < target)
                            early = 1'b1;
                    end
                    if (!early) begin
                        if (fill >= QUEUE_DEPTH) begin
                            r.frame_dropped = 1'b1;
                        end else begin
                            slot              = (head + fill) % QUEUE_DEPTH;
                            ring_pts[slot]    = tv;
                            ring_handle[slot] = x.frame_handle;
                            ring_eos[slot]    = x.frame_is_eos;
                            fill++;
                        end
                    end
                    if (seeking && fill > preroll)
                        seeking = 1'b0;
                end
                hungry = x.decoder_needs_input;
            end
            CMD_QUERY: begin
                if (fill > 0) begin
                    // stale frames go, but the last one always stays
                    while (fill > 1 && ring_pts[head] < tv) begin
                        head = (head + 1) % QUEUE_DEPTH;
                        fill--;
                    end
                    r.frame_valid = 1'b1;
                    r.frame_pts   = ring_pts[head];
                    r.out_handle  = ring_handle[head];
                    r.out_is_eos  = ring_eos[head];
                end
            end
            default: ;
        endcase
        r.can_accept  = (fill < max_cached) && !eos_seen && hungry;
        r.seeking_now = seeking;
        r.eos_played  = eos_seen && (fill <= 1);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in mk_in(logic [2:0] c, logic [TIME_W-1:0] tv,
                                  logic [HANDLE_W-1:0] h, bit p, bit e, bit n);
        t_in x;
        x.cmd                 = c;
        x.time_value          = tv;
        x.frame_handle        = h;
        x.frame_present       = p;
        x.frame_is_eos        = e;
        x.decoder_needs_input = n;
        return x;
    endfunction

    function automatic t_out flags(bit can, bit seek, bit played, bit rej, bit drop);
        t_out r;
        r                 = '0;
        r.can_accept      = can;
        r.seeking_now     = seek;
        r.eos_played      = played;
        r.sample_rejected = rej;
        r.frame_dropped   = drop;
        return r;
    endfunction

    function automatic void add_row(t_in x, bit fixed = 1'b0, t_out w = '0);
        t_row row;
        row.item  = x;
        row.fixed = fixed;
        row.want  = w;
        plan[plan_len] = row;
        plan_len++;
    endfunction

    // Mostly a plausible decode stream: seeks, monotonic frames, queries near
    // the stream clock. Some full-range values and spare commands as noise.
    function automatic t_in random_command(bit force_frame);
        t_in x;
        int  pick;
        x.cmd                 = CMD_UPDATE;
        x.time_value          = {$urandom, $urandom};
        x.frame_handle        = $urandom;
        x.frame_present       = $urandom_range(0, 1);
        x.frame_is_eos        = $urandom_range(0, 1);
        x.decoder_needs_input = $urandom_range(0, 1);
        pick = force_frame ? 30 : $urandom_range(0, 99);
        if (pick < 8) begin
            x.cmd = CMD_SEEK;
            case ($urandom_range(0, 3))
                0: ;
                1: x.time_value[TIME_W-1] = 1'b1;
                default: begin
                    x.time_value = stream_pts + TIME_W'($urandom_range(0, 300));
                    stream_pts   = x.time_value - TIME_W'($urandom_range(0, 150));
                end
            endcase
        end else if (pick < 55) begin
            x.cmd                 = CMD_UPDATE;
            x.frame_present       = force_frame || ($urandom_range(0, 99) < 88);
            x.frame_is_eos        = !force_frame && ($urandom_range(0, 99) < 4);
            x.decoder_needs_input = $urandom_range(0, 99) < 80;
            stream_pts            = stream_pts + TIME_W'($urandom_range(1, 40));
            if ($urandom_range(0, 99) >= 6)
                x.time_value = stream_pts;
        end else if (pick < 63) begin
            x.cmd = CMD_WRITE;
        end else if (pick < 67) begin
            x.cmd = CMD_EOS;
        end else if (pick < 93) begin
            x.cmd = CMD_QUERY;
            if ($urandom_range(0, 99) >= 8)
                x.time_value = stream_pts + TIME_W'($urandom_range(0, 240))
                               - TIME_W'(200);
        end else begin
            x.cmd = 3'($urandom);
        end
        return x;
    endfunction

    // called on a falling edge; returns on the falling edge after acceptance
    // with start still high
    task automatic send_item(t_in x, bit fixed, t_out w);
        int gap;
        if (!steady && $urandom_range(0, 99) < 22) begin
            gap   = $urandom_range(1, 5);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in  = x;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        if (fixed) begin
            void'(predict_presentation(x));
            due_put(w);
        end else begin
            due_put(predict_presentation(x));
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (due_wr != due_rd)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] maxc, logic [CFG_DATA_W-1:0] pre);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = REG_MAX_CACHED;
        i_cfg_data = maxc;
        max_cached = maxc;
        @(negedge i_clk);
        i_cfg_idx  = REG_PREROLL;
        i_cfg_data = pre;
        preroll    = pre[PREROLL_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (due_wr == due_rd) begin
                $error("result transaction with nothing outstanding");
                err_count++;
            end else begin
                want = due_take();
                check_field("frame_valid", want.frame_valid, o_result.frame_valid);
                check_field("frame_pts", want.frame_pts, o_result.frame_pts);
                check_field("out_handle", want.out_handle, o_result.out_handle);
                check_field("out_is_eos", want.out_is_eos, o_result.out_is_eos);
                check_field("can_accept", want.can_accept, o_result.can_accept);
                check_field("seeking_now", want.seeking_now, o_result.seeking_now);
                check_field("eos_played", want.eos_played, o_result.eos_played);
                check_field("sample_rejected", want.sample_rejected,
                            o_result.sample_rejected);
                check_field("frame_dropped", want.frame_dropped, o_result.frame_dropped);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int burst;
        int phase;
        int n;
        int row_idx;
        bit force_frame;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MAX_CACHED;
        i_cfg_data = '0;
        stream_pts = '0;
        burst      = 0;
        reset_queue_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset configuration (12 cached, preroll 8)
        add_row(mk_in(CMD_QUERY, '0, '0, 0, 0, 0), 1, flags(1, 0, 0, 0, 0));
        add_row(mk_in(CMD_SPARE_LO, '1, '1, 1, 1, 1), 1, flags(1, 0, 0, 0, 0));
        add_row(mk_in(CMD_SPARE_MID, '0, '0, 0, 0, 0), 1, flags(1, 0, 0, 0, 0));
        add_row(mk_in(CMD_SPARE_HI, PTS_MIN, '0, 1, 1, 0), 1, flags(1, 0, 0, 0, 0));
        // negative target clamps to zero; a frame at -1 is then too early
        add_row(mk_in(CMD_SEEK, PTS_MIN, '0, 0, 0, 0), 1, flags(1, 1, 0, 0, 0));
        add_row(mk_in(CMD_UPDATE, '1, 32'h1234, 1, 0, 1), 1, flags(1, 1, 0, 0, 0));
        add_row(mk_in(CMD_UPDATE, PTS_MAX, '1, 1, 0, 1));
        add_row(mk_in(CMD_UPDATE, '0, '0, 1, 0, 0), 1, flags(0, 1, 0, 0, 0));
        add_row(mk_in(CMD_UPDATE, '0, '0, 0, 0, 1));
        add_row(mk_in(CMD_WRITE, '0, '0, 0, 0, 0));
        add_row(mk_in(CMD_UPDATE, 64'd5, 32'h5, 1, 1, 1));
        add_row(mk_in(CMD_QUERY, PTS_MIN, '0, 0, 0, 0));
        add_row(mk_in(CMD_EOS, '0, '0, 0, 0, 0));
        add_row(mk_in(CMD_EOS, '0, '0, 0, 0, 0));
        add_row(mk_in(CMD_WRITE, '0, '0, 0, 0, 0), 1, flags(0, 0, 0, 1, 0));
        add_row(mk_in(CMD_SEEK, 64'd100, '0, 0, 0, 0), 1, flags(1, 1, 0, 0, 0));
        add_row(mk_in(CMD_UPDATE, 64'd50, 32'hA0, 1, 0, 1));
        add_row(mk_in(CMD_UPDATE, 64'd100, 32'hA1, 1, 0, 1));
        add_row(mk_in(CMD_UPDATE, 64'd200, 32'hA2, 1, 0, 1));
        add_row(mk_in(CMD_UPDATE, 64'd300, 32'hA3, 1, 0, 1));
        add_row(mk_in(CMD_QUERY, 64'd250, '0, 0, 0, 0));
        add_row(mk_in(CMD_QUERY, PTS_MAX, '0, 0, 0, 0));
        add_row(mk_in(CMD_EOS, '0, '0, 0, 0, 0));
        add_row(mk_in(CMD_QUERY, '0, '0, 0, 0, 0));
        add_row(mk_in(CMD_SEEK, PTS_MAX, '0, 0, 0, 0), 1, flags(1, 1, 0, 0, 0));

        for (row_idx = 0; row_idx < plan_len; row_idx++)
            send_item(plan[row_idx].item, plan[row_idx].fixed, plan[row_idx].want);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: write_config(5'd1, 5'd0);
                2: write_config(5'd16, 5'd15);
                3: write_config(5'd0, 5'd3);
                4: write_config(5'd31, 5'd31);
                5: write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                default: ;
            endcase
            steady = (phase == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                force_frame = burst > 0;
                if (burst > 0)
                    burst--;
                else if ($urandom_range(0, 99) < 3)
                    burst = BURST_LEN;  // enough frames to overrun the ring
                send_item(random_command(force_frame), 1'b0, '0);
            end
        end

        start = 1'b0;
        while (due_wr != due_rd)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
